// ===== hw/rtl/awp_pkg.sv =====
// Package for the arbitrary waveform player: sizes, codes, shared types.
// No dependencies; the divider, the store and the player unit import it.
package awp_pkg;
    localparam int SAMPLES     = 400;
    localparam int FULL_SCALE  = 254;
    localparam int AMP_MAX     = 33;
    localparam int DUTY_MAX    = 100;
    localparam int PHASE_TURN  = 360;
    localparam int MARKER_SPAN = SAMPLES / 20;
    localparam int SIN_A = 51472;
    localparam int SIN_B = 21024;
    localparam int SIN_C = 2320;

    localparam int IDX_W  = $clog2(SAMPLES);
    localparam int CNT_W  = $clog2(SAMPLES + 1);
    localparam int DIV_NW = IDX_W + 16;
    localparam int DIV_DW = (CNT_W > 9) ? CNT_W : 9;
    localparam int DCNT_W = $clog2(DIV_NW + 1);

    // reciprocal multipliers for the divisions by constants (rounded up)
    localparam int AMP_SH    = 18;
    localparam int AMP_RECIP = ((1 << AMP_SH) + AMP_MAX - 1) / AMP_MAX;
    localparam int PEAK_MUL  = FULL_SCALE * AMP_RECIP;
    localparam int DUTY_SH   = 16;
    localparam int DUTY_MUL  = (SAMPLES * (1 << DUTY_SH) + DUTY_MAX - 1) / DUTY_MAX;
    localparam int PH_SH     = 16;
    localparam int PH_MUL    = (SAMPLES * (1 << PH_SH) + PHASE_TURN - 1) / PHASE_TURN;
    localparam int X_SH      = 16;
    localparam longint X_MUL = ((longint'(1) << (15 + X_SH)) + SAMPLES - 1) / SAMPLES;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE = 2'd3;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_BEGIN = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;

    typedef enum logic [2:0] {
        SHAPE_OFF = 3'd0,
        SHAPE_SINE = 3'd1,
        SHAPE_TRI = 3'd2,
        SHAPE_SQUARE = 3'd3,
        SHAPE_ARB = 3'd4
    } t_wave;

    typedef enum logic [3:0] {
        S_IDLE, S_SHAPE, S_DIVW, S_SINX,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_SINE, S_FIN
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
        logic [IDX_W-1:0] raddr;
    } t_store_req;
endpackage

// ===== hw/rtl/awp_in_if.sv =====
// Input channel of the waveform player: action and sample byte.
// Depends on nothing.
interface awp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] sample_byte;
    modport source (output valid, action, sample_byte, input ready);
    modport sink (input valid, action, sample_byte, output ready);
endinterface

// ===== hw/rtl/awp_out_if.sv =====
// Output channel of the waveform player: duty value and marker.
// Depends on nothing.
interface awp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty_value;
    logic       marker;
    modport source (output valid, duty_value, marker, input ready);
    modport sink (input valid, duty_value, marker, output ready);
endinterface

// ===== hw/rtl/awp_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on awp_pkg.
module awp_div import awp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic              ge;
    logic [DIV_DW:0]   diff;

    assign trial = {r_rem, r_quo[DIV_NW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

// ===== hw/rtl/awp_store.sv =====
// Arbitrary sample memory with a fill count; unwritten entries read as zero.
// Depends on awp_pkg.
module awp_store import awp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output logic [7:0] o_rdata
);
    logic [7:0]       mem [SAMPLES];
    logic [7:0]       r_rd;
    logic             r_vld;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] wnext;

    // loads always run upward from zero, so everything below the fill mark is written
    assign wnext = CNT_W'(i_req.waddr) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_req.we && wnext > r_fill) begin
            r_fill <= wnext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd  <= mem[i_req.raddr];
        r_vld <= CNT_W'(i_req.raddr) < r_fill;
    end

    assign o_rdata = r_vld ? r_rd : 8'd0;
endmodule

// ===== hw/rtl/arbitrary_waveform_player_unit.sv =====
// Arbitrary waveform player: one tick word gives one duty value and marker bit.
// On the accepting edge the peak, duty index and marker phase are formed by
// reciprocal multiplication. Off, square, arbitrary and ungated sine ticks
// go from S_SHAPE straight to S_FIN; a gated sine tick runs five
// steps on a shared 17x17 multiplier; a triangle tick always divides on
// the 1-bit-per-cycle divider of DIV_NW (25) steps. The next word is taken
// in the cycle after the result is loaded; a stalled result holds the block
// until it is taken. Load, begin and unused words leave the block in S_IDLE.
// Samples sit in a 400-entry memory; a fill count stands in for clearing it
// at reset, so no clearing pass is needed.
// Depends on awp_pkg, awp_in_if, awp_out_if, awp_div, awp_store.
module arbitrary_waveform_player_unit import awp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    awp_in_if.sink                i_in,
    awp_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_state r_state, n_state;
    logic [2:0] r_wave;
    logic [5:0] r_amp;
    logic [6:0] r_duty;
    logic [8:0] r_phase;
    logic [IDX_W-1:0] r_play;
    logic [CNT_W-1:0] r_load;

    logic [7:0] r_peak, n_peak;
    logic [CNT_W-1:0] r_d, n_d;
    logic [IDX_W-1:0] r_ph, n_ph;
    logic [18:0] r_ascale, n_ascale;
    logic r_marker, n_marker;
    logic r_sub, n_sub;
    logic r_neg, n_neg;
    logic [7:0] r_res, n_res;
    logic [16:0] r_x, n_x, r_x2, n_x2, r_t, n_t, r_u, n_u;
    logic [15:0] r_v, n_v;
    logic [23:0] r_m, n_m;
    logic r_out_valid;
    logic [7:0] r_out_duty;
    logic r_out_marker;

    t_div_req div_req;
    t_div_rsp div_rsp;
    t_store_req st_req;
    logic [7:0] st_rdata;

    logic [16:0] mul_a, mul_b;
    logic [33:0] prod;
    logic [5:0] amp_s;
    logic [6:0] duty_s;
    logic [8:0] ph_s;
    logic [26:0] peak_prod;
    logic [25:0] duty_prod;
    logic [25:0] ph_prod;
    logic [18:0] ascale;
    logic [26:0] arb_prod;
    logic [33:0] x_prod;
    logic [IDX_W-1:0] i_nx;
    logic [IDX_W+1:0] k4, r4;
    logic [1:0] quad;
    logic [IDX_W+1:0] xr;
    logic gate;
    logic [25:0] half_sh, sum_pos;
    logic take_out;
    logic accept;

    awp_div u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));
    awp_store u_store (.i_clk, .i_rst_n, .i_req(st_req), .o_rdata(st_rdata));

    assign accept   = i_in.valid && i_in.ready;
    assign take_out = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign amp_s  = (r_amp > 6'(AMP_MAX)) ? 6'(AMP_MAX) : r_amp;
    assign duty_s = (r_duty > 7'(DUTY_MAX)) ? 7'(DUTY_MAX) : r_duty;
    assign ph_s   = (r_phase >= 9'(PHASE_TURN)) ? 9'd0 : r_phase;
    assign i_nx   = (r_play == IDX_W'(SAMPLES - 1)) ? '0 : r_play + 1'b1;

    // divisions by constants as multiply and shift
    assign peak_prod = 27'(amp_s) * 27'(PEAK_MUL);
    assign duty_prod = 26'(duty_s) * 26'(DUTY_MUL);
    assign ph_prod   = 26'(ph_s) * 26'(PH_MUL);
    assign ascale    = 19'(amp_s) * 19'(AMP_RECIP);
    assign arb_prod  = 27'(st_rdata) * 27'(r_ascale);

    // quadrant of (i+1) mod SAMPLES
    assign k4 = {i_nx, 2'b00};
    always_comb begin
        if (k4 >= (IDX_W+2)'(3 * SAMPLES)) begin
            quad = 2'd3;
            r4 = k4 - (IDX_W+2)'(3 * SAMPLES);
        end else if (k4 >= (IDX_W+2)'(2 * SAMPLES)) begin
            quad = 2'd2;
            r4 = k4 - (IDX_W+2)'(2 * SAMPLES);
        end else if (k4 >= (IDX_W+2)'(SAMPLES)) begin
            quad = 2'd1;
            r4 = k4 - (IDX_W+2)'(SAMPLES);
        end else begin
            quad = 2'd0;
            r4 = k4;
        end
    end
    assign xr = quad[0] ? (IDX_W+2)'(SAMPLES) - r4 : r4;
    assign x_prod = 34'(xr) * 34'(X_MUL);

    assign gate = (CNT_W'(r_play) < (r_d >> 1)) ||
                  ((CNT_W'(r_play) > CNT_W'(SAMPLES / 2)) &&
                   ((CNT_W+1)'(r_play) < (CNT_W+1)'(SAMPLES / 2) + (CNT_W+1)'(r_d >> 1)));

    always_comb begin
        case (r_state)
            S_P1: begin mul_a = r_x; mul_b = r_x; end
            S_P2: begin mul_a = 17'(SIN_C); mul_b = r_x2; end
            S_P3: begin mul_a = 17'(SIN_B) - r_t; mul_b = r_x2; end
            S_P4: begin mul_a = 17'(SIN_A) - r_u; mul_b = r_x; end
            S_P5: begin mul_a = 17'(r_peak); mul_b = 17'(r_v); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign half_sh = {2'b00, 1'b0, r_peak[7:1], 16'd0};
    assign sum_pos = r_neg ? half_sh - 26'(r_m) : half_sh + 26'(r_m);

    always_comb begin
        n_state = r_state;
        n_peak = r_peak; n_d = r_d; n_ph = r_ph; n_ascale = r_ascale; n_marker = r_marker;
        n_sub = r_sub; n_neg = r_neg; n_res = r_res;
        n_x = r_x; n_x2 = r_x2; n_t = r_t; n_u = r_u; n_v = r_v; n_m = r_m;
        div_req.start = 1'b0;
        div_req.num = '0;
        div_req.den = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in.action == ACT_TICK) begin
                    n_peak   = peak_prod[AMP_SH+7:AMP_SH];
                    n_d      = duty_prod[DUTY_SH+CNT_W-1:DUTY_SH];
                    n_ph     = ph_prod[PH_SH+IDX_W-1:PH_SH];
                    n_ascale = ascale;
                    n_state  = S_SHAPE;
                end
            end
            S_SHAPE: begin
                n_marker = (r_play >= r_ph) &&
                           ((IDX_W+1)'(r_play) <=
                            (IDX_W+1)'(r_ph) + (IDX_W+1)'(MARKER_SPAN));
                n_state = S_FIN;
                case (r_wave)
                    SHAPE_SINE: begin
                        n_res = {1'b0, r_peak[7:1]};
                        if (gate) begin
                            n_neg = quad[1];
                            n_state = S_SINX;
                        end
                    end
                    SHAPE_TRI: begin
                        n_res = r_peak;
                        if (CNT_W'(r_play) < r_d) begin
                            n_sub = 1'b0;
                            if (r_d != '0) begin
                                div_req.start = 1'b1;
                                div_req.num = DIV_NW'(r_play) * DIV_NW'(r_peak);
                                div_req.den = DIV_DW'(r_d);
                                n_state = S_DIVW;
                            end
                        end else if (r_d < CNT_W'(SAMPLES)) begin
                            n_sub = 1'b1;
                            div_req.start = 1'b1;
                            div_req.num = DIV_NW'(CNT_W'(r_play) - r_d) *
                                          DIV_NW'(r_peak);
                            div_req.den = DIV_DW'(CNT_W'(SAMPLES) - r_d);
                            n_state = S_DIVW;
                        end
                    end
                    SHAPE_SQUARE: begin
                        n_res = (CNT_W'(r_play) < r_d) ? r_peak : 8'd0;
                    end
                    SHAPE_ARB: begin
                        n_res = arb_prod[AMP_SH+7:AMP_SH];
                    end
                    default: n_res = 8'd0;
                endcase
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    n_res = r_sub ? r_peak - div_rsp.quo[7:0] : div_rsp.quo[7:0];
                    n_state = S_FIN;
                end
            end
            S_SINX: begin
                n_x = x_prod[X_SH+16:X_SH];
                n_state = S_P1;
            end
            S_P1: begin n_x2 = prod[31:15]; n_state = S_P2; end
            S_P2: begin n_t = prod[31:15]; n_state = S_P3; end
            S_P3: begin n_u = prod[31:15]; n_state = S_P4; end
            S_P4: begin
                n_v = (prod[33:15] > 19'd32767) ? 16'd32767 : prod[30:15];
                n_state = S_P5;
            end
            S_P5: begin n_m = prod[23:0]; n_state = S_SINE; end
            S_SINE: begin
                // ceiling of n/65536, zero when n is not positive
                if (r_neg && 26'(r_m) >= half_sh) begin
                    n_res = 8'd0;
                end else begin
                    n_res = 8'((sum_pos + 26'd65535) >> 16);
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (take_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_peak <= n_peak; r_d <= n_d; r_ph <= n_ph; r_ascale <= n_ascale;
        r_marker <= n_marker;
        r_sub <= n_sub; r_neg <= n_neg; r_res <= n_res;
        r_x <= n_x; r_x2 <= n_x2; r_t <= n_t; r_u <= n_u; r_v <= n_v; r_m <= n_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave  <= SHAPE_OFF;
            r_amp   <= 6'd0;
            r_duty  <= 7'd50;
            r_phase <= 9'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WAVE:  r_wave  <= i_cfg_data[2:0];
                CFG_AMP:   r_amp   <= i_cfg_data[5:0];
                CFG_DUTY:  r_duty  <= i_cfg_data[6:0];
                CFG_PHASE: r_phase <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        st_req.we    = accept && i_in.action == ACT_LOAD && r_load < CNT_W'(SAMPLES);
        st_req.waddr = r_load[IDX_W-1:0];
        st_req.wdata = i_in.sample_byte;
        st_req.raddr = r_play;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '0;
            r_play <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && i_in.action == ACT_BEGIN) begin
                r_load <= '0;
            end else if (st_req.we) begin
                r_load <= r_load + 1'b1;
            end
            if (r_state == S_FIN && take_out) begin
                r_play <= i_nx;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && take_out) begin
            r_out_duty   <= r_res;
            r_out_marker <= r_marker;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.duty_value = r_out_duty;
    assign o_out.marker     = r_out_marker;
endmodule
